// File: hw/rtl/cedn_pkg.sv
`default_nettype none

package cedn_pkg;

   // Default geometry
   localparam int unsigned HISTORY_DEPTH_DEF  = 4096;
   localparam int unsigned SINE_ADDR_BITS_DEF = 10;

   // Configuration register indexes
   localparam logic [1:0] CSR_DELAY_SAMPLES = 2'd0;
   localparam logic [1:0] CSR_PHASE_STEP    = 2'd1;
   localparam logic [1:0] CSR_GAIN          = 2'd2;
   localparam logic [1:0] CSR_NOISE_SCALE   = 2'd3;

   localparam logic [15:0] GAIN_RESET = 16'd4096;

   localparam longint Q30_ONE = 64'sd1 << 30;

   // Q30 product, rounded down on both signs
   function automatic longint q30_mul(input longint a, input longint b);
      longint p;
      p = a * b;
      if (p >= 0) begin
         return p >>> 30;
      end
      return -(((-p) + Q30_ONE - 1) >>> 30);
   endfunction

   // Quarter-wave sine entry: 32768*sin(pi/2*k/2^bits), odd polynomial in Q30
   function automatic logic [15:0] sine_value(input int unsigned k, input int unsigned bits);
      longint x;
      longint x2;
      longint p;
      longint s;
      longint v;
      x  = longint'(k) << (30 - bits);
      x2 = q30_mul(x, x);
      p  = -64'sd3864;
      p  = 64'sd172272 + q30_mul(p, x2);
      p  = -64'sd5026995 + q30_mul(p, x2);
      p  = 64'sd85569306 + q30_mul(p, x2);
      p  = -64'sd693598668 + q30_mul(p, x2);
      p  = 64'sd1686629713 + q30_mul(p, x2);
      s  = q30_mul(p, x);
      if (s < 0) begin
         s = 0;
      end
      v = ((s << 15) + (Q30_ONE >>> 1)) >>> 30;
      if (v > 32768) begin
         v = 32768;
      end
      return v[15:0];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cedn_sine_rom.sv
`default_nettype none

module cedn_sine_rom #(
   parameter int unsigned ADDR_BITS = cedn_pkg::SINE_ADDR_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] addr_a,
   input  wire logic [ADDR_BITS:0]   addr_b,
   output logic      [15:0]          data_a,
   output logic      [15:0]          data_b
);

   localparam int unsigned ENTRIES = (1 << ADDR_BITS) + 1;

   logic [15:0] rom [ENTRIES];
   logic [15:0] data_a_ff;
   logic [15:0] data_b_ff;

   for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
      assign rom[k] = cedn_pkg::sine_value(k, ADDR_BITS);
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= rom[{1'b0, addr_a}];
         data_b_ff <= rom[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cedn_delay_line.sv
`default_nettype none

module cedn_delay_line #(
   parameter int unsigned DEPTH = cedn_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  wire logic [31:0] wr_data,        // re [15:0], im [31:16]
   input  wire logic        restart,
   input  wire logic [11:0] delay_samples,
   output logic      [31:0] rd_sample       // zero when history is too short
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned FW = AW + 1;
   localparam int unsigned CW = ((FW > 12) ? FW : 12) + 1;

   logic [31:0]   mem [DEPTH];

   logic [AW-1:0] wp_ff;
   logic [AW-1:0] wp_in;
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;
   logic [FW-1:0] fill_base;
   logic [FW-1:0] fill_new;

   logic [CW-1:0] delay_ext;
   logic [CW-1:0] wp_ext;
   logic [CW-1:0] rd_ext;
   logic [AW-1:0] rd_addr;
   logic          hit;
   logic          bypass;

   logic [31:0]   rd_data_ff;
   logic [31:0]   wr_data_ff;
   logic          hit_ff;
   logic          bypass_ff;

   always_comb begin
      fill_base = restart ? '0 : fill_ff;
      fill_new  = (fill_base < FW'(DEPTH)) ? fill_base + 1'b1 : fill_base;
      fill_in   = wr_en ? fill_new : fill_ff;
      wp_in     = wr_en ? ((wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;

      delay_ext = CW'(delay_samples);
      wp_ext    = CW'(wp_ff);
      hit       = delay_ext < CW'(fill_new);
      rd_ext    = (wp_ext >= delay_ext) ? wp_ext - delay_ext
                                        : wp_ext + CW'(DEPTH) - delay_ext;
      rd_addr   = rd_ext[AW-1:0];
      // zero delay reads the entry being written: take the incoming word
      bypass    = (delay_samples == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= wr_data;
         rd_data_ff <= mem[rd_addr];
         wr_data_ff <= wr_data;
         hit_ff     <= hit;
         bypass_ff  <= bypass;
      end
   end

   assign rd_sample = !hit_ff  ? 32'd0      :
                      bypass_ff ? wr_data_ff : rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/channel_emulator_delay_doppler_noise_top.sv
`default_nettype none

// Channel      | Direction | Handshake            | Payload
// -------------+-----------+----------------------+--------------------------------------
// req_         | in        | req_tvalid/tready    | tdata: sample, noise; tuser: restart
// rsp_         | out       | rsp_tvalid/tready    | tdata: out_re, out_im
// csr_         | in        | csr_we (no wait)     | csr_addr, csr_wdata
//
// Acceptance reads the delay line and sine table; the steps up to the output register
// are rotation products, rotation sums, gain product, then the final sum, truncated
// and saturated. A transaction is taken only from idle, after the previous result loads.
// Reset (synchronous, active high) clears fill count, write pointer, phase and registers;
// the delay store is not cleared, the fill count gates every read of it.
// A stalled output holds its result; the next transaction waits in the last step.

module channel_emulator_delay_doppler_noise_top #(
   parameter int unsigned HISTORY_DEPTH  = cedn_pkg::HISTORY_DEPTH_DEF,
   parameter int unsigned SINE_ADDR_BITS = cedn_pkg::SINE_ADDR_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // sample_re, sample_im, noise_re, noise_im
   input  wire logic        req_tuser,   // restart

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // out_re, out_im

   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   localparam int unsigned SB = SINE_ADDR_BITS;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MUL   = 5'b00010,
      S_ROT   = 5'b00100,
      S_SCALE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [11:0] delay_samples_ff;
   logic [31:0] phase_step_ff;
   logic [15:0] gain_ff;
   logic [15:0] noise_scale_ff;

   logic        accept;
   logic [31:0] phase_ff;
   logic [31:0] phase_base;
   logic [1:0]  quad_ff;
   logic [SB-1:0] sine_idx;
   logic [SB:0]   sine_idx_mirror;
   logic [15:0] sine_a;
   logic [15:0] sine_b;

   logic signed [15:0] noise_re_ff;
   logic signed [15:0] noise_im_ff;

   logic [31:0]        delayed;
   logic signed [15:0] x_re;
   logic signed [15:0] x_im;
   logic signed [16:0] sin_v;
   logic signed [16:0] cos_v;
   logic signed [16:0] pos_a;
   logic signed [16:0] pos_b;

   logic signed [32:0] p_rc_ff;
   logic signed [32:0] p_is_ff;
   logic signed [32:0] p_rs_ff;
   logic signed [32:0] p_ic_ff;
   logic signed [32:0] nz_re_ff;
   logic signed [32:0] nz_im_ff;
   logic signed [33:0] rot_re_ff;
   logic signed [33:0] rot_im_ff;
   logic signed [50:0] sc_re_ff;
   logic signed [50:0] sc_im_ff;
   logic signed [51:0] sum_re;
   logic signed [51:0] sum_im;

   logic        rsp_tvalid_ff;
   logic [31:0] rsp_tdata_ff;
   logic        out_free;
   logic        load_out;

   // truncate toward zero after dropping 27 fraction bits, then saturate
   function automatic logic [15:0] finish(input logic signed [51:0] v);
      logic signed [51:0] adj;
      logic signed [24:0] q;
      adj = v[51] ? v + 52'sd134217727 : v;
      q   = 25'(adj >>> 27);
      if (q > 25'sd32767) begin
         return 16'h7fff;
      end else if (q < -25'sd32768) begin
         return 16'h8000;
      end
      return q[15:0];
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign load_out   = (state_ff == S_DONE) && out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_samples_ff <= '0;
         phase_step_ff    <= '0;
         gain_ff          <= cedn_pkg::GAIN_RESET;
         noise_scale_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            cedn_pkg::CSR_DELAY_SAMPLES: delay_samples_ff <= csr_wdata[11:0];
            cedn_pkg::CSR_PHASE_STEP:    phase_step_ff    <= csr_wdata;
            cedn_pkg::CSR_GAIN:          gain_ff          <= csr_wdata[15:0];
            cedn_pkg::CSR_NOISE_SCALE:   noise_scale_ff   <= csr_wdata[15:0];
         endcase
      end
   end

   // history store
   cedn_delay_line #(
      .DEPTH(HISTORY_DEPTH)
   ) u_delay (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (accept),
      .wr_data      (req_tdata[31:0]),
      .restart      (req_tuser),
      .delay_samples(delay_samples_ff),
      .rd_sample    (delayed)
   );

   // phase: restart clears it before use, advance after the lookup
   always_comb begin
      phase_base      = req_tuser ? 32'd0 : phase_ff;
      sine_idx        = phase_base[29 -: SB];
      sine_idx_mirror = (SB + 1)'(1 << SB) - {1'b0, sine_idx};
   end

   cedn_sine_rom #(
      .ADDR_BITS(SB)
   ) u_sine (
      .clock (clock),
      .rd_en (accept),
      .addr_a(sine_idx),
      .addr_b(sine_idx_mirror),
      .data_a(sine_a),
      .data_b(sine_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_base + phase_step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         quad_ff     <= phase_base[31:30];
         noise_re_ff <= signed'(req_tdata[47:32]);
         noise_im_ff <= signed'(req_tdata[63:48]);
      end
   end

   // quadrant folding of the quarter-wave table
   always_comb begin
      x_re  = signed'(delayed[15:0]);
      x_im  = signed'(delayed[31:16]);
      pos_a = signed'({1'b0, sine_a});
      pos_b = signed'({1'b0, sine_b});
      unique case (quad_ff)
         2'd0: begin
            sin_v = pos_a;
            cos_v = pos_b;
         end
         2'd1: begin
            sin_v = pos_b;
            cos_v = -pos_a;
         end
         2'd2: begin
            sin_v = -pos_a;
            cos_v = -pos_b;
         end
         default: begin
            sin_v = -pos_b;
            cos_v = pos_a;
         end
      endcase
   end

   // arithmetic steps, one per state
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         p_rc_ff  <= x_re * cos_v;
         p_is_ff  <= x_im * sin_v;
         p_rs_ff  <= x_re * sin_v;
         p_ic_ff  <= x_im * cos_v;
         nz_re_ff <= noise_re_ff * signed'({1'b0, noise_scale_ff});
         nz_im_ff <= noise_im_ff * signed'({1'b0, noise_scale_ff});
      end
      if (state_ff == S_ROT) begin
         rot_re_ff <= 34'(p_rc_ff) - 34'(p_is_ff);
         rot_im_ff <= 34'(p_rs_ff) + 34'(p_ic_ff);
      end
      if (state_ff == S_SCALE) begin
         sc_re_ff <= rot_re_ff * signed'({1'b0, gain_ff});
         sc_im_ff <= rot_im_ff * signed'({1'b0, gain_ff});
      end
   end

   always_comb begin
      sum_re = 52'(sc_re_ff) + (52'(nz_re_ff) <<< 11);
      sum_im = 52'(sc_im_ff) + (52'(nz_im_ff) <<< 11);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept)   state_in = S_MUL;
         S_MUL:                 state_in = S_ROT;
         S_ROT:                 state_in = S_SCALE;
         S_SCALE:               state_in = S_DONE;
         S_DONE:  if (out_free) state_in = S_IDLE;
         default:               state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tdata_ff <= {finish(sum_im), finish(sum_re)};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

// File: tb/tb_channel_emulator_delay_doppler_noise_top.sv
`timescale 1ns / 1ps

module tb_channel_emulator_delay_doppler_noise_top;

   localparam int unsigned DEPTH     = cedn_pkg::HISTORY_DEPTH_DEF;
   localparam int unsigned SINE_BITS = cedn_pkg::SINE_ADDR_BITS_DEF;
   localparam int unsigned SINE_N    = 1 << SINE_BITS;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   // four steps to the output register, with margin
   localparam int unsigned SETTLE_CYCLES   = 12;

   typedef struct {
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
      logic signed [15:0] noise_re;
      logic signed [15:0] noise_im;
      logic               restart;
   } req_item_type;

   typedef struct {
      logic [15:0] out_re;
      logic [15:0] out_im;
   } channel_out_type;

   typedef enum logic [1:0] {
      QUAD_FIRST, QUAD_SECOND, QUAD_THIRD, QUAD_FOURTH
   } quadrant_type;

   // DUT ports; every input known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // sample_re, sample_im, noise_re, noise_im
   logic        req_tuser  = 1'b0; // restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // out_re, out_im
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [31:0] csr_wdata  = '0;

   // Shared test controls
   bit          idle_enable  = 1'b1;
   bit          hold_request = 1'b0;
   int unsigned error_count  = 0;

   // Predictor state: delay line, pointers, Doppler phase and the register copies
   logic [31:0] delay_line [0:DEPTH-1];
   logic [11:0] write_ptr;
   int unsigned fill_level;
   logic [31:0] doppler_phase;
   logic [11:0] cfg_delay;
   logic [31:0] cfg_step;
   logic [15:0] cfg_gain;
   logic [15:0] cfg_noise_scale;
   int          quarter_sine [0:SINE_N];

   channel_out_type expected_outputs [$];

   channel_emulator_delay_doppler_noise_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop: far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("channel_emulator_delay_doppler_noise_top regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sine table and predictor
   // ------------------------------------------------------------------

   // Q30 product; floor on both signs, which equals the ceiling-and-negate
   // form used for negative products
   function automatic longint mul_q30(input longint a, input longint b);
      return (a * b) >>> 30;
   endfunction

   // Fill the quarter wave: 32768*sin(pi/2*k/N) from an odd degree-11 polynomial
   function automatic void build_quarter_sine();
      longint x, x2, acc, s, v;
      for (int unsigned k = 0; k <= SINE_N; k++) begin
         x   = longint'(k) << (30 - SINE_BITS);
         x2  = mul_q30(x, x);
         acc = -64'sd3864;
         acc = 64'sd172272      + mul_q30(acc, x2);
         acc = -64'sd5026995    + mul_q30(acc, x2);
         acc = 64'sd85569306    + mul_q30(acc, x2);
         acc = -64'sd693598668  + mul_q30(acc, x2);
         acc = 64'sd1686629713  + mul_q30(acc, x2);
         s   = mul_q30(acc, x);
         if (s < 0) s = 0;
         v = ((s << 15) + (64'sd1 << 29)) >>> 30;
         if (v > 32768) v = 32768;
         quarter_sine[k] = int'(v);
      end
   endfunction

   // Drop the fraction toward zero, then clip to 16 bits
   function automatic logic [15:0] clip_to_16(input longint num);
      longint v;
      v = num / (64'sd1 << 27);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic void reset_predictor();
      write_ptr       = '0;
      fill_level      = 0;
      doppler_phase   = '0;
      cfg_delay       = '0;
      cfg_step        = '0;
      cfg_gain        = cedn_pkg::GAIN_RESET;
      cfg_noise_scale = '0;
      expected_outputs.delete();
   endfunction

   // Advance the channel by one sample and queue the output it produces
   function automatic void predict_channel_output(input req_item_type it);
      logic [11:0]     rd_ptr;
      longint          xr, xi, sn, cs, rr, ri, nr, ni, g, ns;
      int unsigned     ix;
      quadrant_type    quad;
      channel_out_type res;
      if (it.restart) begin
         fill_level    = 0;
         doppler_phase = '0;
      end
      delay_line[write_ptr] = {it.sample_im, it.sample_re};
      if (fill_level < DEPTH) fill_level++;
      xr = 0;
      xi = 0;
      // only history written since the last restart may be picked
      if (cfg_delay < fill_level) begin
         rd_ptr = write_ptr - cfg_delay;
         xr = longint'(signed'(delay_line[rd_ptr][15:0]));
         xi = longint'(signed'(delay_line[rd_ptr][31:16]));
      end
      write_ptr = write_ptr + 12'd1;

      quad = quadrant_type'(doppler_phase[31:30]);
      ix   = (doppler_phase >> (30 - SINE_BITS)) & (SINE_N - 1);
      case (quad)
         QUAD_FIRST: begin
            sn = quarter_sine[ix];           cs = quarter_sine[SINE_N - ix];
         end
         QUAD_SECOND: begin
            sn = quarter_sine[SINE_N - ix];  cs = -quarter_sine[ix];
         end
         QUAD_THIRD: begin
            sn = -quarter_sine[ix];          cs = -quarter_sine[SINE_N - ix];
         end
         default: begin
            sn = -quarter_sine[SINE_N - ix]; cs = quarter_sine[ix];
         end
      endcase
      doppler_phase = doppler_phase + cfg_step;

      g  = cfg_gain;
      ns = cfg_noise_scale;
      rr = xr * cs - xi * sn;
      ri = xr * sn + xi * cs;
      nr = longint'(it.noise_re) * ns * 2048;
      ni = longint'(it.noise_im) * ns * 2048;
      res.out_re = clip_to_16(rr * g + nr);
      res.out_im = clip_to_16(ri * g + ni);
      expected_outputs.push_back(res);
   endfunction

   // ------------------------------------------------------------------
   // Monitor: follow resets and register writes, predict on every accepted
   // input transaction and check every accepted output transaction.
   // Values are sampled at the edge, before that edge's updates land.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      channel_out_type got, want;
      req_item_type    taken;
      if (reset) begin
         reset_predictor();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_re = rsp_tdata[15:0];
            got.out_im = rsp_tdata[31:16];
            if (expected_outputs.size() == 0) begin
               $display("%0t: unexpected output transaction re=%0d im=%0d", $time,
                        $signed(got.out_re), $signed(got.out_im));
               error_count++;
            end else begin
               want = expected_outputs.pop_front();
               if (got.out_re !== want.out_re) begin
                  $display("%0t: out_re expected %0d actual %0d", $time,
                           $signed(want.out_re), $signed(got.out_re));
                  error_count++;
               end
               if (got.out_im !== want.out_im) begin
                  $display("%0t: out_im expected %0d actual %0d", $time,
                           $signed(want.out_im), $signed(got.out_im));
                  error_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_addr)
               cedn_pkg::CSR_DELAY_SAMPLES: cfg_delay       = csr_wdata[11:0];
               cedn_pkg::CSR_PHASE_STEP:    cfg_step        = csr_wdata;
               cedn_pkg::CSR_GAIN:          cfg_gain        = csr_wdata[15:0];
               cedn_pkg::CSR_NOISE_SCALE:   cfg_noise_scale = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            taken.sample_re = req_tdata[15:0];
            taken.sample_im = req_tdata[31:16];
            taken.noise_re  = req_tdata[47:32];
            taken.noise_im  = req_tdata[63:48];
            taken.restart   = req_tuser;
            predict_channel_output(taken);
         end
      end
   end

   // ------------------------------------------------------------------
   // Output side: random stall bursts, and on request one long hold-off
   // so that the block fills up and pushes back on its input.
   // ------------------------------------------------------------------
   initial begin : output_side
      int unsigned stall;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 8);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Input side and register helpers
   // ------------------------------------------------------------------

   // Offer one input transaction, maybe after an idle burst; keep tvalid
   // high afterwards so back-to-back items need no extra step
   task automatic send_item(input req_item_type it);
      int unsigned gap;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.noise_im, it.noise_re, it.sample_im, it.sample_re};
      req_tuser  <= it.restart;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic req_item_type make_item(input logic [15:0] s_re,
                                              input logic [15:0] s_im,
                                              input logic [15:0] n_re,
                                              input logic [15:0] n_im,
                                              input logic rst);
      req_item_type it;
      it.sample_re = s_re;
      it.sample_im = s_im;
      it.noise_re  = n_re;
      it.noise_im  = n_im;
      it.restart   = rst;
      return it;
   endfunction

   // Mostly uniform, with the corners of the range mixed in
   function automatic logic [15:0] random_word();
      case ($urandom_range(0, 11))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic req_item_type random_item(input int unsigned restart_odds);
      return make_item(random_word(), random_word(), random_word(), random_word(),
                       $urandom_range(1, restart_odds) == 1);
   endfunction

   // Drop tvalid, wait for every expected output, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Program all four registers with the block idle
   task automatic configure(input logic [11:0] dly, input logic [31:0] step,
                            input logic [15:0] g, input logic [15:0] nscale);
      settle();
      write_reg(cedn_pkg::CSR_DELAY_SAMPLES, {20'd0, dly});
      write_reg(cedn_pkg::CSR_PHASE_STEP, step);
      write_reg(cedn_pkg::CSR_GAIN, {16'd0, g});
      write_reg(cedn_pkg::CSR_NOISE_SCALE, {16'd0, nscale});
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values: no delay, no rotation, unity gain, noise off, so the
   // output must equal the input whatever the noise inputs carry
   task automatic test_reset_defaults();
      send_item(make_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1));
      send_item(make_item(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0));
      send_item(make_item(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
      send_item(make_item(16'hFFFF, 16'h0001, 16'h1234, 16'hEDCB, 1'b0));
   endtask

   // Delay line: output zero until enough history, restart clears the fill
   // but keeps the write pointer; the largest delay gives zero with this short history
   task automatic test_delay_line();
      configure(12'd2, 32'd0, cedn_pkg::GAIN_RESET, 16'd0);
      send_item(make_item(16'h1111, 16'hEEEE, 16'h0000, 16'h0000, 1'b1));
      send_item(make_item(16'h2222, 16'hDDDD, 16'h0000, 16'h0000, 1'b0));
      send_item(make_item(16'h3333, 16'hCCCC, 16'h0000, 16'h0000, 1'b0));
      send_item(make_item(16'h4444, 16'hBBBB, 16'h0000, 16'h0000, 1'b1));
      send_item(make_item(16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 1'b0));
      send_item(make_item(16'h6666, 16'h9999, 16'h0000, 16'h0000, 1'b0));
      configure(12'hFFF, 32'd0, cedn_pkg::GAIN_RESET, 16'd0);
      send_item(make_item(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b0));
   endtask

   // Doppler: a quarter turn per sample walks through all four quadrants;
   // the largest step lands on the top index of the fourth quadrant
   task automatic test_doppler_rotation();
      configure(12'd0, 32'h4000_0000, cedn_pkg::GAIN_RESET, 16'd0);
      send_item(make_item(16'h4000, 16'h1000, 16'h0000, 16'h0000, 1'b1));
      send_item(make_item(16'h4000, 16'h1000, 16'h0000, 16'h0000, 1'b0));
      send_item(make_item(16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b0));
      send_item(make_item(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b0));
      configure(12'd0, 32'hFFFF_FFFF, cedn_pkg::GAIN_RESET, 16'd0);
      send_item(make_item(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b1));
      send_item(make_item(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0));
   endtask

   // Largest gain and noise scale drive both rails; zero gain leaves noise only
   task automatic test_gain_noise_saturation();
      configure(12'd0, 32'd0, 16'hFFFF, 16'hFFFF);
      send_item(make_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
      send_item(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
      send_item(make_item(16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 1'b0));
      configure(12'd1, 32'd0, 16'd0, 16'd1);
      send_item(make_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0));
   endtask

   // Several random settings, a hundred samples each, with the odd restart
   task automatic test_random_stream();
      logic [11:0] dly;
      logic [31:0] step;
      logic [15:0] g, nscale;
      for (int ph = 0; ph < 5; ph++) begin
         case ($urandom_range(0, 4))
            0:       dly = 12'd0;
            1:       dly = 12'($urandom_range(1, 8));
            2:       dly = 12'($urandom_range(9, 120));
            3:       dly = 12'hFFF;
            default: dly = 12'($urandom_range(0, 4095));
         endcase
         case ($urandom_range(0, 3))
            0:       step = 32'd0;
            1:       step = 32'hFFFF_FFFF;
            2:       step = $urandom_range(0, 32'h00FF_FFFF);
            default: step = $urandom();
         endcase
         case ($urandom_range(0, 3))
            0:       g = cedn_pkg::GAIN_RESET;
            1:       g = 16'hFFFF;
            2:       g = 16'($urandom_range(2048, 8192));
            default: g = 16'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 2))
            0:       nscale = 16'd0;
            1:       nscale = 16'($urandom_range(1, 64));
            default: nscale = 16'($urandom_range(0, 65535));
         endcase
         configure(dly, step, g, nscale);
         for (int n = 0; n < 100; n++) send_item(random_item(40));
      end
   endtask

   // Hold the output off for a long stretch while inputs keep coming
   task automatic test_backpressure();
      configure(12'd3, $urandom(), 16'h1800, 16'd16);
      hold_request = 1'b1;
      for (int n = 0; n < 30; n++) send_item(random_item(20));
   endtask

   // Last stretch: no idling on either side
   task automatic test_full_rate();
      configure(12'($urandom_range(0, 20)), $urandom(), cedn_pkg::GAIN_RESET,
                16'($urandom_range(0, 32)));
      idle_enable = 1'b0;
      for (int n = 0; n < 80; n++) send_item(random_item(30));
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      build_quarter_sine();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_delay_line();
      test_doppler_rotation();
      test_gain_noise_saturation();
      test_random_stream();
      test_backpressure();
      test_full_rate();
      settle();

      if (error_count == 0) begin
         $display("channel_emulator_delay_doppler_noise_top regression: pass");
      end else begin
         $display("channel_emulator_delay_doppler_noise_top regression: fail");
      end
      $finish;
   end

endmodule
